@@ hdl/atl_pkg.sv @@
// Shared types, constants and helper functions for the assembly token lexer.
// Used by the channel interfaces and every lexer module; depends on nothing.
`timescale 1ns / 1ps

package atl_pkg;

  // Field widths.
  localparam int POS_WIDTH  = 24;
  localparam int LINE_WIDTH = 20;
  localparam int KIND_WIDTH = 5;
  localparam int CH_WIDTH   = 8;

  // Saturation limits and the value a line count restarts at.
  localparam logic [POS_WIDTH-1:0]  POS_MAX   = {POS_WIDTH{1'b1}};
  localparam logic [LINE_WIDTH-1:0] LINE_MAX  = {LINE_WIDTH{1'b1}};
  localparam logic [LINE_WIDTH-1:0] LINE_INIT = LINE_WIDTH'(1);

  // Token kinds beyond the twenty mnemonics.
  localparam logic [KIND_WIDTH-1:0] KIND_REG    = KIND_WIDTH'(20);
  localparam logic [KIND_WIDTH-1:0] KIND_PORT   = KIND_WIDTH'(21);
  localparam logic [KIND_WIDTH-1:0] KIND_LABEL  = KIND_WIDTH'(22);
  localparam logic [KIND_WIDTH-1:0] KIND_SYMBOL = KIND_WIDTH'(23);
  localparam logic [KIND_WIDTH-1:0] KIND_COMMA  = KIND_WIDTH'(24);

  // Character codes with a meaning of their own.
  localparam logic [CH_WIDTH-1:0] CH_NUL     = 8'h00;
  localparam logic [CH_WIDTH-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CH_WIDTH-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CH_WIDTH-1:0] CH_PERCENT = 8'h25;
  localparam logic [CH_WIDTH-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CH_WIDTH-1:0] CH_DOT     = 8'h2E;
  localparam logic [CH_WIDTH-1:0] CH_SEMI    = 8'h3B;

  // Mnemonic table, first character in the top byte; index is the kind code.
  localparam int NUM_MNEMONICS = 20;
  localparam logic [23:0] MNEMONIC [NUM_MNEMONICS] = '{
    "MSC", "SST", "SLD", "SLP", "PST", "PLD", "CND", "LIM", "RST", "AST",
    "INC", "RSH", "ADD", "SUB", "XOR", "POI", "NOP", "JMP", "MST", "MLD"
  };

  // Word-length counter, saturating at its all-ones value.
  localparam int LEN_WIDTH = 3;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX      = {LEN_WIDTH{1'b1}};
  localparam logic [LEN_WIDTH-1:0] LEN_MNEMONIC = LEN_WIDTH'(3);

  // Result queue sizing.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

  // One result token.
  typedef struct packed {
    logic [KIND_WIDTH-1:0] kind;
    logic [POS_WIDTH-1:0]  start_pos;
    logic [POS_WIDTH-1:0]  end_pos;
    logic [LINE_WIDTH-1:0] line_number;
    logic                  last;
  } token_t;

  // Up to two tokens produced by one byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } scan_out_t;

  // Letters, digits, '.', '$' and '%'.
  function automatic logic is_word_byte(logic [CH_WIDTH-1:0] c);
    logic hit;
    hit = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
          ((c >= "0") && (c <= "9")) ||
          (c == CH_DOT) || (c == CH_DOLLAR) || (c == CH_PERCENT);
    return hit;
  endfunction

  // Kind of a finished word from its first three bytes (first byte lowest).
  function automatic logic [KIND_WIDTH-1:0] classify_word(logic [23:0] fc,
                                                          logic [LEN_WIDTH-1:0] len);
    logic [23:0]           key;
    logic [KIND_WIDTH-1:0] kind;
    key = {fc[7:0], fc[15:8], fc[23:16]};
    case (fc[7:0])
      CH_DOLLAR:  kind = KIND_REG;
      CH_PERCENT: kind = KIND_PORT;
      CH_DOT:     kind = KIND_LABEL;
      default:    kind = KIND_SYMBOL;
    endcase
    if (len == LEN_MNEMONIC) begin
      for (int i = NUM_MNEMONICS - 1; i >= 0; i--) begin
        if (key == MNEMONIC[i]) begin
          kind = KIND_WIDTH'(i);
        end
      end
    end
    return kind;
  endfunction

endpackage

@@ hdl/atl_byte_if.sv @@
// Valid/ready channel that carries one source text byte per transfer.
// Depends on atl_pkg for the byte width.
`timescale 1ns / 1ps

interface atl_byte_if;
  logic                          valid;
  logic                          ready;
  logic [atl_pkg::CH_WIDTH-1:0]  ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

@@ hdl/atl_token_if.sv @@
// Valid/ready channel that carries one token per transfer.
// Depends on atl_pkg for the field widths.
`timescale 1ns / 1ps

interface atl_token_if;
  logic                            valid;
  logic                            ready;
  logic [atl_pkg::KIND_WIDTH-1:0]  token_kind;
  logic [atl_pkg::POS_WIDTH-1:0]   start_pos;
  logic [atl_pkg::POS_WIDTH-1:0]   end_pos;
  logic [atl_pkg::LINE_WIDTH-1:0]  line_number;
  logic                            last;

  modport source (output valid, output token_kind, output start_pos, output end_pos,
                  output line_number, output last, input ready);
  modport sink   (input valid, input token_kind, input start_pos, input end_pos,
                  input line_number, input last, output ready);
endinterface

@@ hdl/atl_scan.sv @@
// Lexer state and per-byte scan logic: turns one byte into zero to two tokens.
// Depends on atl_pkg.
`timescale 1ns / 1ps

module atl_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [atl_pkg::CH_WIDTH-1:0] ch,
  output atl_pkg::scan_out_t           res
);

  // Control state.
  logic                              in_word, in_word_next;
  logic                              in_comment, in_comment_next;
  logic [atl_pkg::POS_WIDTH-1:0]     position, position_next;
  logic [atl_pkg::LINE_WIDTH-1:0]    line_count, line_count_next;
  logic [atl_pkg::LEN_WIDTH-1:0]     word_length, word_length_next;

  // Word details, always written when a word opens.
  logic [atl_pkg::POS_WIDTH-1:0]     word_start, word_start_next;
  logic [atl_pkg::LINE_WIDTH-1:0]    word_line, word_line_next;
  logic [23:0]                       first_chars, first_chars_next;

  logic                              word_byte;
  logic                              word_tok;
  logic                              comma_tok;
  logic [atl_pkg::POS_WIDTH-1:0]     pos_inc;
  atl_pkg::token_t                   word_t;
  atl_pkg::token_t                   comma_t;

  // Next state and the tokens this byte causes.
  always_comb begin
    in_word_next     = in_word;
    in_comment_next  = in_comment;
    position_next    = position;
    line_count_next  = line_count;
    word_length_next = word_length;
    word_start_next  = word_start;
    word_line_next   = word_line;
    first_chars_next = first_chars;
    comma_tok        = 1'b0;

    word_byte = atl_pkg::is_word_byte(ch);
    pos_inc   = (position == atl_pkg::POS_MAX) ? position
                                               : position + atl_pkg::POS_WIDTH'(1);
    word_tok  = in_word && !word_byte;

    if (in_word && word_byte) begin
      // Word continues; keep its first three bytes.
      case (word_length)
        atl_pkg::LEN_WIDTH'(1): first_chars_next[15:8]  = ch;
        atl_pkg::LEN_WIDTH'(2): first_chars_next[23:16] = ch;
        default: ;
      endcase
      if (word_length != atl_pkg::LEN_MAX) begin
        word_length_next = word_length + atl_pkg::LEN_WIDTH'(1);
      end
      position_next = pos_inc;
    end else begin
      in_word_next = 1'b0;
      if (ch == atl_pkg::CH_NUL) begin
        position_next    = '0;
        line_count_next  = atl_pkg::LINE_INIT;
        in_comment_next  = 1'b0;
        word_length_next = '0;
      end else if (ch == atl_pkg::CH_NEWLINE) begin
        in_comment_next = 1'b0;
        if (line_count != atl_pkg::LINE_MAX) begin
          line_count_next = line_count + atl_pkg::LINE_WIDTH'(1);
        end
        position_next = pos_inc;
      end else if (in_comment) begin
        position_next = pos_inc;
      end else if (ch == atl_pkg::CH_SEMI) begin
        in_comment_next = 1'b1;
        position_next   = pos_inc;
      end else if (ch == atl_pkg::CH_COMMA) begin
        comma_tok     = 1'b1;
        position_next = pos_inc;
      end else if (word_byte) begin
        in_word_next     = 1'b1;
        word_start_next  = position;
        word_line_next   = line_count;
        word_length_next = atl_pkg::LEN_WIDTH'(1);
        first_chars_next = {16'h0000, ch};
        position_next    = pos_inc;
      end else begin
        position_next = pos_inc;
      end
    end

    word_t.kind        = atl_pkg::classify_word(first_chars, word_length);
    word_t.start_pos   = word_start;
    word_t.end_pos     = position;
    word_t.line_number = word_line;
    word_t.last        = !comma_tok;

    comma_t.kind        = atl_pkg::KIND_COMMA;
    comma_t.start_pos   = position;
    comma_t.end_pos     = pos_inc;
    comma_t.line_number = line_count;
    comma_t.last        = 1'b1;

    // A word token always goes ahead of a comma caused by the same byte.
    res.tok0  = word_tok ? word_t : comma_t;
    res.tok1  = comma_t;
    res.count = take ? (2'(word_tok) + 2'(comma_tok)) : 2'd0;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_word     <= 1'b0;
      in_comment  <= 1'b0;
      position    <= '0;
      line_count  <= atl_pkg::LINE_INIT;
      word_length <= '0;
    end else if (take) begin
      in_word     <= in_word_next;
      in_comment  <= in_comment_next;
      position    <= position_next;
      line_count  <= line_count_next;
      word_length <= word_length_next;
    end
  end

  // Word detail registers need no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      word_start  <= word_start_next;
      word_line   <= word_line_next;
      first_chars <= first_chars_next;
    end
  end

endmodule

@@ hdl/atl_token_fifo.sv @@
// Small result queue: takes up to two tokens per cycle, hands out one per transfer.
// Depends on atl_pkg and atl_token_if.
`timescale 1ns / 1ps

module atl_token_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  atl_pkg::scan_out_t            wr,
  atl_token_if.source                   tokens,
  output logic [atl_pkg::LEVEL_W-1:0]   level
);

  atl_pkg::token_t                 mem [atl_pkg::FIFO_DEPTH];
  logic [atl_pkg::FIFO_AW-1:0]     wptr;
  logic [atl_pkg::FIFO_AW-1:0]     rptr;
  logic [atl_pkg::FIFO_AW-1:0]     wptr_1;
  logic                            rd;
  atl_pkg::token_t                 head;

  assign wptr_1 = wptr + atl_pkg::FIFO_AW'(1);
  assign rd     = tokens.valid && tokens.ready;
  assign head   = mem[rptr];

  // Output side shows the oldest entry.
  assign tokens.valid       = (level != '0);
  assign tokens.token_kind  = head.kind;
  assign tokens.start_pos   = head.start_pos;
  assign tokens.end_pos     = head.end_pos;
  assign tokens.line_number = head.line_number;
  assign tokens.last        = head.last;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      mem[wptr] <= wr.tok0;
    end
    if (wr.count == 2'd2) begin
      mem[wptr_1] <= wr.tok1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + atl_pkg::FIFO_AW'(wr.count);
      rptr  <= rptr + atl_pkg::FIFO_AW'(rd);
      level <= level + atl_pkg::LEVEL_W'(wr.count) - atl_pkg::LEVEL_W'(rd);
    end
  end

endmodule

@@ hdl/assembly_token_lexer.sv @@
// Assembly token lexer top level: input byte register, scan logic, result queue.
// Depends on atl_pkg, atl_byte_if, atl_token_if, atl_scan and atl_token_fifo.
//
// Usage:
//   text carries one source byte per transfer; a zero byte ends the text and
//   returns position to 0 and line to 1. tokens carries one token per
//   transfer: kind, start and end byte positions, start line, and last, which
//   marks the final token caused by one byte (a byte causes at most two).
//   A word is reported when the byte after it arrives.
// Path: a byte is registered at its transfer, scanned once the result queue
//   has room, and its tokens are then offered on the tokens channel.
// Throughput: one byte per cycle; the result queue drains one token per
//   cycle while tokens.ready is high, so a byte that causes two tokens
//   takes two output transfers. The input register is scanned only while
//   the four-entry result queue has room for two tokens.
// Reset: rst (synchronous) empties the queue and the input register and
//   restarts at position 0, line 1, outside any word or comment.
// Stall: while tokens.ready is low the queue fills and text.ready falls;
//   nothing is lost or repeated.
`timescale 1ns / 1ps

module assembly_token_lexer (
  input  logic          clk,
  input  logic          rst,
  atl_byte_if.sink      text,
  atl_token_if.source   tokens
);

  logic                            byte_valid;
  logic [atl_pkg::CH_WIDTH-1:0]    byte_r;
  logic                            room;
  logic                            consume;
  logic [atl_pkg::LEVEL_W-1:0]     level;
  atl_pkg::scan_out_t              scan_res;

  // Scan the held byte only when the queue can take two tokens.
  assign room       = (level <= atl_pkg::LEVEL_W'(atl_pkg::FIFO_DEPTH - 2));
  assign consume    = byte_valid && room;
  assign text.ready = !byte_valid || consume;

  // Input byte register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      byte_valid <= 1'b1;
    end else if (consume) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      byte_r <= text.ch;
    end
  end

  atl_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (consume),
    .ch   (byte_r),
    .res  (scan_res)
  );

  atl_token_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (scan_res),
    .tokens (tokens),
    .level  (level)
  );

`ifndef NO_ASSERTIONS
  // The queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= atl_pkg::LEVEL_W'(atl_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // Fill level tracks writes and output transfers exactly.
  a_level_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> level == $past(level) + atl_pkg::LEVEL_W'($past(scan_res.count))
                             - atl_pkg::LEVEL_W'($past(tokens.valid && tokens.ready)))
    else $error("result queue level out of step");

  // Two tokens from one byte are a word then a comma, last only on the second.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    scan_res.count == 2'd2 |-> scan_res.tok0.kind != atl_pkg::KIND_COMMA &&
      scan_res.tok1.kind == atl_pkg::KIND_COMMA && !scan_res.tok0.last &&
      scan_res.tok1.last)
    else $error("token pair out of order");
`endif

endmodule
